/* rtl/assert_macros.svh */
// Assertion macros for the RTL modules; the controller uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent on the same edge, idle during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: label");

`endif

/* rtl/bfmc_pkg.sv */
// Package for the buffer frame manager: opcodes, status codes and control structs.
`default_nettype none
package bfmc_pkg;

    // Request opcodes
    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_ALLOC   = 3'd1;
    localparam logic [2:0] OP_UNPIN   = 3'd2;
    localparam logic [2:0] OP_DISPOSE = 3'd3;
    localparam logic [2:0] OP_FLUSH   = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ALL_PINNED = 3'd1;
    localparam logic [2:0] ST_NOT_PINNED = 3'd2;
    localparam logic [2:0] ST_PAGE_PINNED = 3'd3;
    localparam logic [2:0] ST_BAD_REQ    = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       pin;
        logic       take;
        logic       unpin;
        logic       clear;
        logic       clr_ref;
        logic       adv_hand;
        logic       emit;
        logic       use_frame;
        logic       hit;
        logic       need_read;
        logic       wb;
        logic [2:0] status;
        logic       last;
    } t_cmd;

    // Status from datapath to controller, for the frame at the current address
    typedef struct packed {
        logic out_busy;
        logic valid;
        logic referenced;
        logic pin_zero;
        logic match_page;
        logic match_file;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/bfmc_dp.sv */
// Datapath: frame table, clock hand, request latch and result register.
`default_nettype none
module bfmc_dp #(
    parameter int NUM_FRAMES   = 16,
    parameter int FILE_ID_BITS = 8,
    parameter int PAGE_BITS    = 32,
    parameter int PIN_BITS     = 8,
    parameter int IW           = 4,
    parameter int OUT_W        = 48
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire bfmc_pkg::t_cmd          i_cmd,
    input  wire logic [IW-1:0]           i_addr,
    input  wire logic [FILE_ID_BITS-1:0] i_file_id,
    input  wire logic [PAGE_BITS-1:0]    i_page_no,
    input  wire logic                    i_dirty_flag,
    output bfmc_pkg::t_stat              o_stat,
    output logic [IW-1:0]                o_hand_next,
    input  wire logic                    i_out_ready,
    output logic                         o_out_valid,
    output logic [OUT_W-1:0]             o_out_data,
    output logic [2:0]                   o_out_status,
    output logic                         o_out_last
);
    import bfmc_pkg::*;

    localparam int USED_W = IW + 3 + FILE_ID_BITS + PAGE_BITS;
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    logic [NUM_FRAMES-1:0]   r_valid, r_dirty, r_ref;
    logic [PIN_BITS-1:0]     r_pin  [NUM_FRAMES];
    logic [FILE_ID_BITS-1:0] r_file [NUM_FRAMES];
    logic [PAGE_BITS-1:0]    r_page [NUM_FRAMES];
    logic [IW-1:0]           r_hand;
    logic [FILE_ID_BITS-1:0] r_req_file;
    logic [PAGE_BITS-1:0]    r_req_page;
    logic                    r_req_dirty;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;
    logic [2:0]              r_out_status;
    logic                    r_out_last;

    logic                    w_wb;
    logic [FILE_ID_BITS-1:0] w_wbf;
    logic [PAGE_BITS-1:0]    w_wbp;
    logic [IW-1:0]           w_frame;

    // Next hand position with wrap
    assign o_hand_next = (r_hand == IW'(NUM_FRAMES - 1)) ? '0 : r_hand + 1'b1;

    // Status of the addressed frame
    always_comb begin
        o_stat.out_busy   = r_out_valid;
        o_stat.valid      = r_valid[i_addr];
        o_stat.referenced = r_ref[i_addr];
        o_stat.pin_zero   = (r_pin[i_addr] == '0);
        o_stat.match_file = r_valid[i_addr] && (r_file[i_addr] == r_req_file);
        o_stat.match_page = o_stat.match_file && (r_page[i_addr] == r_req_page);
    end

    // Result fields
    assign w_wb    = i_cmd.wb && r_valid[i_addr] && r_dirty[i_addr];
    assign w_wbf   = w_wb ? r_file[i_addr] : '0;
    assign w_wbp   = w_wb ? r_page[i_addr] : '0;
    assign w_frame = i_cmd.use_frame ? i_addr : '0;

    // Control state of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_ref   <= '0;
            r_hand  <= IW'(NUM_FRAMES - 1);
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_pin[i] <= '0;
            end
        end else begin
            if (i_cmd.adv_hand) begin
                r_hand <= o_hand_next;
            end
            if (i_cmd.clr_ref) begin
                r_ref[i_addr] <= 1'b0;
            end
            if (i_cmd.pin) begin
                r_ref[i_addr] <= 1'b1;
                if (r_pin[i_addr] != PIN_MAX) begin
                    r_pin[i_addr] <= r_pin[i_addr] + 1'b1;
                end
            end
            if (i_cmd.take) begin
                r_valid[i_addr] <= 1'b1;
                r_dirty[i_addr] <= 1'b0;
                r_ref[i_addr]   <= 1'b1;
                r_pin[i_addr]   <= PIN_BITS'(1);
            end
            if (i_cmd.unpin) begin
                r_pin[i_addr] <= r_pin[i_addr] - 1'b1;
                if (r_req_dirty) begin
                    r_dirty[i_addr] <= 1'b1;
                end
            end
            if (i_cmd.clear) begin
                r_valid[i_addr] <= 1'b0;
                r_dirty[i_addr] <= 1'b0;
                r_ref[i_addr]   <= 1'b0;
                r_pin[i_addr]   <= '0;
            end
        end
    end

    // Page tags and request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_file[i_addr] <= r_req_file;
            r_page[i_addr] <= r_req_page;
        end
        if (i_cmd.load_req) begin
            r_req_file  <= i_file_id;
            r_req_page  <= i_page_no;
            r_req_dirty <= i_dirty_flag;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data   <= OUT_W'({w_wbp, w_wbf, w_wb, i_cmd.need_read, i_cmd.hit, w_frame});
            r_out_status <= i_cmd.status;
            r_out_last   <= i_cmd.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

    // USED_W must fit the packed result
    if (USED_W > OUT_W) begin : g_width_bad
        assign o_out_data[0] = 1'bx;
    end

endmodule
`default_nettype wire

/* rtl/bfmc_ctrl.sv */
// Controller: sequences lookup, victim search and flush walk over the frame table.
`default_nettype none
`include "assert_macros.svh"
module bfmc_ctrl #(
    parameter int NUM_FRAMES = 16,
    parameter int IW         = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire logic [2:0]      i_opcode,
    input  wire bfmc_pkg::t_stat i_stat,
    input  wire logic [IW-1:0]   i_hand_next,
    output bfmc_pkg::t_cmd       o_cmd,
    output logic [IW-1:0]        o_addr
);
    import bfmc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_ACT   = 3'd2;
    localparam logic [2:0] S_VICT  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_FRAMES - 1);
    localparam logic [IW:0]   LAST_STEP = (IW+1)'(2 * NUM_FRAMES - 1);

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_op, n_op;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW:0]   r_step, n_step;
    logic [2:0]    r_status, n_status;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_idx    = r_idx;
        n_step   = r_step;
        n_status = r_status;
        o_cmd    = '0;
        o_addr   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_op  = i_opcode;
                    n_idx = '0;
                    if (i_opcode > OP_FLUSH) begin
                        n_status = ST_BAD_REQ;
                        n_state  = S_EMIT;
                    end else if (i_opcode == OP_FLUSH) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            // Linear scan for the requested page
            S_LOOK: begin
                if (i_stat.match_page) begin
                    n_state = S_ACT;
                end else if (r_idx == LAST_IDX) begin
                    if (r_op inside {OP_READ, OP_ALLOC}) begin
                        n_step  = '0;
                        n_state = S_VICT;
                    end else begin
                        n_status = ST_OK;
                        n_state  = S_EMIT;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // Act on the resident frame
            S_ACT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.use_frame = 1'b1;
                    o_cmd.hit       = 1'b1;
                    o_cmd.last      = 1'b1;
                    o_cmd.status    = ST_OK;
                    n_state         = S_IDLE;
                    case (r_op)
                        OP_READ, OP_ALLOC: o_cmd.pin = 1'b1;
                        OP_UNPIN: begin
                            if (i_stat.pin_zero) begin
                                o_cmd.status = ST_NOT_PINNED;
                            end else begin
                                o_cmd.unpin = 1'b1;
                            end
                        end
                        default: o_cmd.clear = 1'b1;
                    endcase
                end
            end
            // Clock sweep, one frame a cycle while the result register is free
            S_VICT: begin
                o_addr = i_hand_next;
                if (!i_stat.out_busy) begin
                    o_cmd.adv_hand = 1'b1;
                    if (!i_stat.valid || (!i_stat.referenced && i_stat.pin_zero)) begin
                        o_cmd.take      = 1'b1;
                        o_cmd.emit      = 1'b1;
                        o_cmd.use_frame = 1'b1;
                        o_cmd.need_read = (r_op == OP_READ);
                        o_cmd.wb        = 1'b1;
                        o_cmd.status    = ST_OK;
                        o_cmd.last      = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.clr_ref = i_stat.referenced;
                        n_step = r_step + 1'b1;
                        if (r_step == LAST_STEP) begin
                            n_status = ST_ALL_PINNED;
                            n_state  = S_EMIT;
                        end
                    end
                end
            end
            // Flush walk from frame zero upward
            S_FLUSH: begin
                if (!i_stat.out_busy) begin
                    if (i_stat.match_file) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.use_frame = 1'b1;
                        if (!i_stat.pin_zero) begin
                            o_cmd.status = ST_PAGE_PINNED;
                            o_cmd.last   = 1'b1;
                        end else begin
                            o_cmd.wb    = 1'b1;
                            o_cmd.clear = 1'b1;
                        end
                    end
                    if (i_stat.match_file && !i_stat.pin_zero) begin
                        n_state = S_IDLE;
                    end else if (r_idx == LAST_IDX) begin
                        n_status = ST_OK;
                        n_state  = S_EMIT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            // Single closing result with only a status
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = r_status;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_step   <= n_step;
        r_status <= n_status;
    end

    `ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, o_cmd.emit, !i_stat.out_busy)
    `ASSERT_IMPL(a_take_ok, i_clk, i_rst_n, o_cmd.take,
                 !i_stat.valid || (!i_stat.referenced && i_stat.pin_zero))
    `ASSERT_IMPL(a_hand_vict, i_clk, i_rst_n, o_cmd.adv_hand, r_state == S_VICT)
    `ASSERT_NEVER(a_flush_no_take, i_clk, i_rst_n, (r_state == S_FLUSH) && o_cmd.take)

endmodule
`default_nettype wire

/* rtl/buffer_frame_manager_clock_core.sv */
// Top level of the buffer frame manager with clock replacement.
//
// Requests enter on s_axis: tuser carries the opcode, tdata the file, page
// and dirty flag. Results leave on m_axis: tdata carries frame index, hit,
// need_read, writeback and the writeback file and page; tuser the status;
// tlast marks the final result of a request.
// One request is handled at a time; s_axis_tready is high only when idle.
// Lookup scans the frames one per cycle; a miss on a read or alloc then runs
// the clock sweep one frame per cycle while the output register is free, over
// up to 2*NUM_FRAMES frames; a flush walks the frames from frame zero, one
// transfer per matching frame and a closing status transfer, and stops at the
// first pinned match, whose result is the last. A hit is acted on in the act
// state, which writes its result into the output register.
// Results go through a one-entry output register; when the receiver stalls,
// the controller holds its walk until the register is free.
// Reset (synchronous, active low) clears valid, dirty, reference bits and
// pin counts and puts the clock hand on the last frame.
`default_nettype none
module buffer_frame_manager_clock_core #(
    parameter int NUM_FRAMES   = 16,
    parameter int FILE_ID_BITS = 8,
    parameter int PAGE_BITS    = 32,
    parameter int PIN_BITS     = 8,
    localparam int IW          = $clog2(NUM_FRAMES),
    localparam int IN_W        = ((FILE_ID_BITS + PAGE_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_W       = ((IW + 3 + FILE_ID_BITS + PAGE_BITS + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // file_id, page, dirty_flag
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    // opcode
    input  wire logic [2:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // frame_index, hit, need_read, writeback, wb_file_id, wb_page
    output logic [OUT_W-1:0]      m_axis_tdata,
    // status
    output logic [2:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);
    import bfmc_pkg::*;

    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [IW-1:0] w_addr;
    logic [IW-1:0] w_hand_next;

    bfmc_ctrl #(
        .NUM_FRAMES (NUM_FRAMES),
        .IW         (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_stat      (w_stat),
        .i_hand_next (w_hand_next),
        .o_cmd       (w_cmd),
        .o_addr      (w_addr)
    );

    bfmc_dp #(
        .NUM_FRAMES   (NUM_FRAMES),
        .FILE_ID_BITS (FILE_ID_BITS),
        .PAGE_BITS    (PAGE_BITS),
        .PIN_BITS     (PIN_BITS),
        .IW           (IW),
        .OUT_W        (OUT_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_addr        (w_addr),
        .i_file_id     (s_axis_tdata[FILE_ID_BITS-1:0]),
        .i_page_no     (s_axis_tdata[FILE_ID_BITS +: PAGE_BITS]),
        .i_dirty_flag  (s_axis_tdata[FILE_ID_BITS + PAGE_BITS]),
        .o_stat        (w_stat),
        .o_hand_next   (w_hand_next),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata),
        .o_out_status  (m_axis_tuser),
        .o_out_last    (m_axis_tlast)
    );

endmodule
`default_nettype wire
